>>> src/image_size_fit_and_crop_defines.svh
// assertion macros shared by the image size fit and crop block
// each macro expects clk and arst_n in scope
`ifndef IMAGE_SIZE_FIT_AND_CROP_DEFINES_SVH
`define IMAGE_SIZE_FIT_AND_CROP_DEFINES_SVH

// same-cycle implication
`define ISFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/isfc_pkg.sv
package isfc_pkg;

	localparam int DIM_BITS_DEF = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int MODE_W       = 3;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_W = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_H = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_W    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_H    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIENT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ENLARGE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RMAX     = 3'd7;

	typedef enum logic [MODE_W-1:0] {
		FIT_NONE   = 3'd0,
		FIT_INSIDE = 3'd1,
		FIT_WIDTH  = 3'd2,
		FIT_HEIGHT = 3'd3,
		FIT_FILL   = 3'd4
	} fit_mode_t;

	// reset values
	localparam int TARGET_W_RST = 640;
	localparam int TARGET_H_RST = 480;
	localparam int MAX_W_RST    = 640;
	localparam int MAX_H_RST    = 480;

endpackage

>>> src/isfc_src_if.sv
interface isfc_src_if #(
	parameter int DIM_BITS = isfc_pkg::DIM_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] src_width;
	logic [DIM_BITS-1:0] src_height;

	modport source (output valid, src_width, src_height, input ready);
	modport sink (input valid, src_width, src_height, output ready);
endinterface

>>> src/isfc_res_if.sv
interface isfc_res_if #(
	parameter int DIM_BITS = isfc_pkg::DIM_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic [DIM_BITS-1:0] fitted_width;
	logic [DIM_BITS-1:0] fitted_height;
	logic [DIM_BITS-1:0] crop_x;
	logic [DIM_BITS-1:0] crop_y;
	logic [DIM_BITS-1:0] crop_width;
	logic [DIM_BITS-1:0] crop_height;
	logic                scaled;

	modport source (output valid, fitted_width, fitted_height, crop_x, crop_y,
		crop_width, crop_height, scaled, input ready);
	modport sink (input valid, fitted_width, fitted_height, crop_x, crop_y,
		crop_width, crop_height, scaled, output ready);
endinterface

>>> src/image_size_fit_and_crop.sv
// image size fit and crop
// src_ch carries one source size (src_width, src_height) per transaction; res_ch
// returns one result transaction per source: fitted size, centered crop
// rectangle inside the source and the scaled flag. cfg_we/cfg_idx/cfg_data
// write the mode, target, max and option registers; write them only while
// no transaction is in flight.
// two bit-serial restoring dividers in series, each 2*DIM_BITS+2 stages,
// lie on the path from source to result
// throughput: one transaction per cycle unless res_ch stalls; every stage is a plain pipeline stage
// reset clears all valid bits and loads the register defaults (640x480 target
// and max, exact fill, orientation on, no enlarge, no max clamp)
// a stall on res_ch freezes the whole pipeline in place, src_ch.ready drops in
// the same cycle and nothing is lost or repeated
`include "image_size_fit_and_crop_defines.svh"

module image_size_fit_and_crop #(
	parameter int DIM_BITS = isfc_pkg::DIM_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [isfc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [DIM_BITS-1:0]          cfg_data,
	isfc_src_if.sink                     src_ch,
	isfc_res_if.source                   res_ch
);
	import isfc_pkg::*;

	localparam int D  = DIM_BITS;
	localparam int P  = 2 * DIM_BITS;   // product width
	localparam int NW = P + 2;          // rounded numerator 2n+d
	localparam int DW = D + 1;          // rounded divisor 2d

	// tag through the first divider
	typedef struct packed {
		logic [D-1:0] sw;
		logic [D-1:0] sh;
		logic [D-1:0] twp;
		logic [D-1:0] thp;
		logic [P-1:0] n2c;
		logic [D-1:0] d2c;
		logic         big;
		logic         lt;
		logic         act;
	} tag1_t;

	// tag through the second divider
	typedef struct packed {
		logic [D-1:0] sw;
		logic [D-1:0] sh;
		logic [D-1:0] fw;
		logic [D-1:0] fh;
		logic [D-1:0] cq;
		logic         big;
		logic         sc;
		logic         over;
		logic         crop_on;
		logic         crop_q1;
		logic         lt;
	} tag2_t;

	localparam int T1W = $bits(tag1_t);
	localparam int T2W = $bits(tag2_t);

	function automatic logic [D-1:0] sat_dim(input logic [NW-1:0] v);
		if (|v[NW-1:D]) begin
			return '1;
		end
		return v[D-1:0];
	endfunction

	function automatic logic [NW-1:0] ext_dim(input logic [D-1:0] v);
		return {{(NW-D){1'b0}}, v};
	endfunction

	// (sub0(a, q) + 1) / 2
	function automatic logic [D-1:0] half_gap(input logic [D-1:0] a, input logic [D-1:0] q);
		logic [D:0] t;
		t = (a > q) ? ({1'b0, a - q} + 1'b1) : {{D{1'b0}}, 1'b1};
		return t[D:1];
	endfunction

	// configuration registers
	logic [D-1:0]      tw_q, th_q, mw_q, mh_q;
	logic [MODE_W-1:0] fit_mode_q;
	logic              orient_q, enlarge_q, rmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tw_q       <= D'(TARGET_W_RST);
			th_q       <= D'(TARGET_H_RST);
			mw_q       <= D'(MAX_W_RST);
			mh_q       <= D'(MAX_H_RST);
			fit_mode_q <= FIT_FILL;
			orient_q   <= 1'b1;
			enlarge_q  <= 1'b0;
			rmax_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TARGET_W: tw_q       <= cfg_data;
				CFG_TARGET_H: th_q       <= cfg_data;
				CFG_MAX_W:    mw_q       <= cfg_data;
				CFG_MAX_H:    mh_q       <= cfg_data;
				CFG_MODE:     fit_mode_q <= cfg_data[MODE_W-1:0];
				CFG_ORIENT:   orient_q   <= cfg_data[0];
				CFG_ENLARGE:  enlarge_q  <= cfg_data[0];
				CFG_RMAX:     rmax_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// mode decode; keeping it static while transactions are in flight is up to the user, the block has no check
	logic mode_inside, mode_width, mode_height, mode_fill, mode_none;
	assign mode_inside = fit_mode_q == FIT_INSIDE;
	assign mode_width  = fit_mode_q == FIT_WIDTH;
	assign mode_height = fit_mode_q == FIT_HEIGHT;
	assign mode_fill   = fit_mode_q == FIT_FILL;
	// none and the undefined codes pass the source through
	assign mode_none   = !(mode_inside || mode_width || mode_height || mode_fill);

	// global advance: the output slot is empty or being taken
	logic v_s5;
	logic pipe_en;
	assign pipe_en      = !v_s5 || res_ch.ready;
	assign src_ch.ready = pipe_en;

	// stage 1: capture the source size
	logic         v_s1;
	logic [D-1:0] sw_s1, sh_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pipe_en) begin
			v_s1 <= src_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sw_s1 <= src_ch.src_width;
			sh_s1 <= src_ch.src_height;
		end
	end

	// stage 2: orientation swap, active test and the three cross products
	logic         swap_c, act_c;
	logic [D-1:0] twp_c, thp_c, twx_c, thx_c;
	logic [P-1:0] a_c, b_c, c_c;

	always_comb begin
		swap_c = (mode_inside || mode_fill) && orient_q && (sw_s1 < sh_s1) && (tw_q > th_q);
		twp_c  = swap_c ? th_q : tw_q;
		thp_c  = swap_c ? tw_q : th_q;
		// operands of the centered crop for each mode
		if (mode_width) begin
			twx_c = tw_q;
			thx_c = mh_q;
		end else if (mode_height) begin
			twx_c = mw_q;
			thx_c = th_q;
		end else begin
			twx_c = twp_c;
			thx_c = thp_c;
		end
		if (mode_inside || mode_fill) begin
			act_c = enlarge_q || (sw_s1 > twp_c) || (sh_s1 > thp_c);
		end else if (mode_width) begin
			act_c = enlarge_q || (sw_s1 > tw_q);
		end else if (mode_height) begin
			act_c = enlarge_q || (sh_s1 > th_q);
		end else begin
			act_c = 1'b0;
		end
	end

	assign a_c = {{D{1'b0}}, sw_s1} * {{D{1'b0}}, thx_c};
	assign b_c = {{D{1'b0}}, sh_s1} * {{D{1'b0}}, twx_c};
	assign c_c = {{D{1'b0}}, twp_c} * {{D{1'b0}}, thp_c};

	logic         v_s2, act_s2;
	logic [D-1:0] sw_s2, sh_s2, twp_s2, thp_s2, twx_s2, thx_s2;
	logic [P-1:0] a_s2, b_s2, c_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pipe_en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			act_s2 <= act_c;
			sw_s2  <= sw_s1;
			sh_s2  <= sh_s1;
			twp_s2 <= twp_c;
			thp_s2 <= thp_c;
			twx_s2 <= twx_c;
			thx_s2 <= thx_c;
			a_s2   <= a_c;
			b_s2   <= b_c;
			c_s2   <= c_c;
		end
	end

	// stage 3: aspect compare, first division operands
	logic         lt_c, big_c;
	logic [P-1:0] n1_c;
	logic [D-1:0] d1_c;
	tag1_t        tag1_c;

	always_comb begin
		lt_c  = a_s2 < b_s2;
		big_c = sw_s2 > sh_s2;
		if (mode_inside) begin
			n1_c = big_c ? b_s2 : a_s2;
			d1_c = big_c ? sw_s2 : sh_s2;
		end else if (mode_width) begin
			n1_c = b_s2;
			d1_c = sw_s2;
		end else if (mode_height) begin
			n1_c = a_s2;
			d1_c = sh_s2;
		end else begin
			// exact fill crop, also harmless for pass-through
			n1_c = lt_c ? a_s2 : b_s2;
			d1_c = lt_c ? twx_s2 : thx_s2;
		end
		tag1_c.sw  = sw_s2;
		tag1_c.sh  = sh_s2;
		tag1_c.twp = twp_s2;
		tag1_c.thp = thp_s2;
		// second division: refit for fit inside, crop for the clamped modes
		tag1_c.n2c = mode_inside ? c_s2 : (lt_c ? a_s2 : b_s2);
		tag1_c.d2c = lt_c ? twx_s2 : thx_s2;
		tag1_c.big = big_c;
		tag1_c.lt  = lt_c;
		tag1_c.act = act_s2;
	end

	logic          v_s3;
	logic [NW-1:0] n1_s3;
	logic [DW-1:0] d1_s3;
	tag1_t         tag1_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (pipe_en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			n1_s3   <= {1'b0, n1_c, 1'b0} + ext_dim(d1_c);
			d1_s3   <= {d1_c, 1'b0};
			tag1_s3 <= tag1_c;
		end
	end

	// first divider
	logic           v_d1;
	logic [NW-1:0]  q1;
	logic [T1W-1:0] tag1_d1_vec;
	tag1_t          tag1_d1;

	isfc_rdiv_pipe #(
		.NUM_W (NW),
		.DEN_W (DW),
		.TAG_W (T1W)
	) u_div1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s3),
		.num       (n1_s3),
		.den       (d1_s3),
		.tag_in    (tag1_s3),
		.out_valid (v_d1),
		.quo       (q1),
		.tag_out   (tag1_d1_vec)
	);

	assign tag1_d1 = tag1_t'(tag1_d1_vec);

	// stage 4: fitted size from the first quotient, second division operands
	logic [D-1:0]  q1s;
	logic [NW-1:0] side_c;
	logic [P-1:0]  n2_c;
	logic [D-1:0]  d2_c;
	tag2_t         tag2_c;

	always_comb begin
		q1s            = sat_dim(q1);
		side_c         = '0;
		n2_c           = tag1_d1.n2c;
		d2_c           = tag1_d1.d2c;
		tag2_c.sw      = tag1_d1.sw;
		tag2_c.sh      = tag1_d1.sh;
		tag2_c.fw      = tag1_d1.sw;
		tag2_c.fh      = tag1_d1.sh;
		tag2_c.cq      = q1s;
		tag2_c.big     = tag1_d1.big;
		tag2_c.sc      = 1'b0;
		tag2_c.over    = 1'b0;
		tag2_c.crop_on = 1'b0;
		tag2_c.crop_q1 = 1'b0;
		tag2_c.lt      = tag1_d1.lt;
		if (tag1_d1.act) begin
			if (mode_inside) begin
				// fits in the target side, refit if the other side overflows
				d2_c = q1[D-1:0];
				if (tag1_d1.big) begin
					tag2_c.fw = tag1_d1.twp;
					tag2_c.fh = q1s;
					tag2_c.sc = tag1_d1.twp != tag1_d1.sw;
					if (q1 > ext_dim(tag1_d1.thp)) begin
						tag2_c.fh   = tag1_d1.thp;
						tag2_c.sc   = 1'b1;
						tag2_c.over = 1'b1;
					end
				end else begin
					tag2_c.fh = tag1_d1.thp;
					tag2_c.fw = q1s;
					tag2_c.sc = tag1_d1.thp != tag1_d1.sh;
					if (q1 > ext_dim(tag1_d1.twp)) begin
						tag2_c.fw   = tag1_d1.twp;
						tag2_c.sc   = 1'b1;
						tag2_c.over = 1'b1;
					end
				end
			end else if (mode_width) begin
				side_c     = (tag1_d1.sw != tw_q) ? q1 : ext_dim(tag1_d1.sh);
				tag2_c.fw  = tw_q;
				tag2_c.fh  = sat_dim(side_c);
				tag2_c.sc  = tag1_d1.sw != tw_q;
				if (rmax_q && (side_c > ext_dim(mh_q))) begin
					tag2_c.fh      = mh_q;
					tag2_c.crop_on = 1'b1;
				end
			end else if (mode_height) begin
				side_c     = (tag1_d1.sh != th_q) ? q1 : ext_dim(tag1_d1.sw);
				tag2_c.fh  = th_q;
				tag2_c.fw  = sat_dim(side_c);
				tag2_c.sc  = tag1_d1.sh != th_q;
				if (rmax_q && (side_c > ext_dim(mw_q))) begin
					tag2_c.fw      = mw_q;
					tag2_c.crop_on = 1'b1;
				end
			end else if (mode_fill) begin
				tag2_c.fw      = tag1_d1.twp;
				tag2_c.fh      = tag1_d1.thp;
				tag2_c.sc      = (tag1_d1.sw != tag1_d1.twp) || (tag1_d1.sh != tag1_d1.thp);
				tag2_c.crop_on = 1'b1;
				tag2_c.crop_q1 = 1'b1;
			end
		end
	end

	logic          v_s4;
	logic [NW-1:0] n2_s4;
	logic [DW-1:0] d2_s4;
	tag2_t         tag2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (pipe_en) begin
			v_s4 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			n2_s4   <= {1'b0, n2_c, 1'b0} + ext_dim(d2_c);
			d2_s4   <= {d2_c, 1'b0};
			tag2_s4 <= tag2_c;
		end
	end

	// second divider
	logic           v_d2;
	logic [NW-1:0]  q2;
	logic [T2W-1:0] tag2_d2_vec;
	tag2_t          tag2_d2;

	isfc_rdiv_pipe #(
		.NUM_W (NW),
		.DEN_W (DW),
		.TAG_W (T2W)
	) u_div2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (v_s4),
		.num       (n2_s4),
		.den       (d2_s4),
		.tag_in    (tag2_s4),
		.out_valid (v_d2),
		.quo       (q2),
		.tag_out   (tag2_d2_vec)
	);

	assign tag2_d2 = tag2_t'(tag2_d2_vec);

	// stage 5: final size and crop rectangle into the output register
	logic [D-1:0] q2s, cqv, fw_c, fh_c, cx_c, cy_c, cw_c, ch_c;

	always_comb begin
		q2s  = sat_dim(q2);
		cqv  = tag2_d2.crop_q1 ? tag2_d2.cq : q2s;
		fw_c = tag2_d2.fw;
		fh_c = tag2_d2.fh;
		if (tag2_d2.over) begin
			if (tag2_d2.big) begin
				fw_c = q2s;
			end else begin
				fh_c = q2s;
			end
		end
		cx_c = '0;
		cy_c = '0;
		cw_c = tag2_d2.sw;
		ch_c = tag2_d2.sh;
		if (tag2_d2.crop_on) begin
			if (tag2_d2.lt) begin
				// source taller than the wanted aspect
				cy_c = half_gap(tag2_d2.sh, cqv);
				ch_c = cqv;
			end else begin
				cx_c = half_gap(tag2_d2.sw, cqv);
				cw_c = cqv;
			end
		end
	end

	logic [D-1:0] fw_s5, fh_s5, cx_s5, cy_s5, cw_s5, ch_s5;
	logic         sc_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (pipe_en) begin
			v_s5 <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fw_s5 <= fw_c;
			fh_s5 <= fh_c;
			cx_s5 <= cx_c;
			cy_s5 <= cy_c;
			cw_s5 <= cw_c;
			ch_s5 <= ch_c;
			sc_s5 <= tag2_d2.sc;
		end
	end

	assign res_ch.valid         = v_s5;
	assign res_ch.fitted_width  = fw_s5;
	assign res_ch.fitted_height = fh_s5;
	assign res_ch.crop_x        = cx_s5;
	assign res_ch.crop_y        = cy_s5;
	assign res_ch.crop_width    = cw_s5;
	assign res_ch.crop_height   = ch_s5;
	assign res_ch.scaled        = sc_s5;

	// pass-through modes give the whole source as crop and no scaling
	`ISFC_ASSERT_NOW(a_none_pass, res_ch.valid && mode_none,
		res_ch.fitted_width == res_ch.crop_width && res_ch.fitted_height == res_ch.crop_height && !res_ch.scaled,
		"pass-through result differs from source")
	// fit inside never crops
	`ISFC_ASSERT_NOW(a_inside_whole, res_ch.valid && mode_inside,
		res_ch.crop_x == '0 && res_ch.crop_y == '0, "fit inside produced an offset crop")
	// a stall freezes the valid bits of stages 1, 3, 4 and 5
	`ISFC_ASSERT_NEXT(a_stall_hold, !pipe_en,
		$stable(v_s1) && $stable(v_s3) && $stable(v_s4) && $stable(v_s5),
		"pipeline moved during a stall")

endmodule

>>> src/isfc_rdiv_pipe.sv
// restoring divider, one quotient bit per stage, tag rides along
module isfc_rdiv_pipe #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 17,
	parameter int TAG_W = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  logic [TAG_W-1:0] tag_in,
	output logic             out_valid,
	output logic [NUM_W-1:0] quo,
	output logic [TAG_W-1:0] tag_out
);

	logic             v_s   [NUM_W];
	logic [DEN_W-1:0] rem_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [TAG_W-1:0] tag_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic             prev_v;
		logic [DEN_W-1:0] prev_rem;
		logic [DEN_W-1:0] prev_den;
		logic [NUM_W-1:0] prev_num;
		logic [NUM_W-1:0] prev_quo;
		logic [TAG_W-1:0] prev_tag;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (i == 0) begin : g_first
			assign prev_v   = in_valid;
			assign prev_rem = '0;
			assign prev_den = den;
			assign prev_num = num;
			assign prev_quo = '0;
			assign prev_tag = tag_in;
		end else begin : g_next
			assign prev_v   = v_s[i-1];
			assign prev_rem = rem_s[i-1];
			assign prev_den = den_s[i-1];
			assign prev_num = num_s[i-1];
			assign prev_quo = quo_s[i-1];
			assign prev_tag = tag_s[i-1];
		end

		assign trial = {prev_rem, prev_num[NUM_W-1]};
		assign diff  = trial - {1'b0, prev_den};
		assign ge    = trial >= {1'b0, prev_den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= prev_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				den_s[i] <= prev_den;
				num_s[i] <= {prev_num[NUM_W-2:0], 1'b0};
				quo_s[i] <= {prev_quo[NUM_W-2:0], ge};
				tag_s[i] <= prev_tag;
			end
		end
	end

	// zero divisor gives zero
	assign out_valid = v_s[NUM_W-1];
	assign quo       = (den_s[NUM_W-1] == '0) ? '0 : quo_s[NUM_W-1];
	assign tag_out   = tag_s[NUM_W-1];

endmodule

>>> sim/tb_image_size_fit_and_crop.sv
`timescale 1ns / 100ps

module tb_image_size_fit_and_crop;
	import isfc_pkg::*;

	localparam int DW = 16;
	localparam int LATENCY = 2 * (2 * DW + 2) + 4;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [DW-1:0] w;
		logic [DW-1:0] h;
	} src_size_t;

	typedef struct packed {
		logic [DW-1:0] fw;
		logic [DW-1:0] fh;
		logic [DW-1:0] cx;
		logic [DW-1:0] cy;
		logic [DW-1:0] cw;
		logic [DW-1:0] ch;
		logic          sc;
	} fit_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [DW-1:0] cfg_data;

	isfc_src_if #(.DIM_BITS(DW)) src_ch ();
	isfc_res_if #(.DIM_BITS(DW)) res_ch ();

	image_size_fit_and_crop #(.DIM_BITS(DW)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.src_ch(src_ch), .res_ch(res_ch)
	);

	// predictor copy of the registers
	logic [DW-1:0] p_tw, p_th, p_mw, p_mh;
	logic [2:0] p_mode;
	logic p_orient, p_enlarge, p_rmax;

	src_size_t   pending_sizes[$];
	fit_result_t expected_fits[$];
	int  fail_count = 0;
	int  results_seen = 0;
	int  idle_cycles = 0;
	bit  hold_sender = 0;
	bit  in_fire = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// rounded quotient, half up; zero divisor gives zero
	function automatic longint unsigned round_div(longint unsigned a, longint unsigned b);
		if (b == 0) return 0;
		return (2 * a + b) / (2 * b);
	endfunction

	function automatic longint unsigned clip_dim(longint unsigned v);
		return (v > 65535) ? 65535 : v;
	endfunction

	// centered crop of the source to the aspect of (tw, th)
	function automatic void center_crop(input longint unsigned sw, sh, tw, th,
			output longint unsigned cx, cy, cw, ch);
		longint unsigned n;
		if (sw * th < tw * sh) begin
			n = round_div(sw * th, tw);
			cx = 0;
			cy = (((sh > n) ? sh - n : 0) + 1) / 2;
			cw = sw;
			ch = n;
		end else begin
			n = round_div(sh * tw, th);
			cx = (((sw > n) ? sw - n : 0) + 1) / 2;
			cy = 0;
			cw = n;
			ch = sh;
		end
	endfunction

	function automatic fit_result_t predict_fit(src_size_t s);
		longint unsigned sw, sh, tw, th, fw, fh, cx, cy, cw, ch, t;
		bit sc;
		fit_result_t r;
		sw = s.w; sh = s.h; tw = p_tw; th = p_th;
		fw = sw; fh = sh; cx = 0; cy = 0; cw = sw; ch = sh; sc = 0;
		// portrait source swaps a landscape target
		if ((p_mode == FIT_INSIDE || p_mode == FIT_FILL) && p_orient && sw < sh && tw > th) begin
			t = tw; tw = th; th = t;
		end
		case (p_mode)
			FIT_INSIDE: begin
				if (p_enlarge || sw > tw || sh > th) begin
					if (sw > sh) begin
						fw = tw; fh = round_div(sh * tw, sw); sc = (tw != sw);
						if (fh > th) begin
							fw = round_div(fw * th, fh); fh = th; sc = 1;
						end
					end else begin
						fh = th; fw = round_div(sw * th, sh); sc = (th != sh);
						if (fw > tw) begin
							fh = round_div(fh * tw, fw); fw = tw; sc = 1;
						end
					end
				end
			end
			FIT_WIDTH: begin
				if (p_enlarge || sw > tw) begin
					if (sw != tw) begin
						fw = tw; fh = round_div(tw * sh, sw); sc = 1;
					end
					if (p_rmax && fh > p_mh) begin
						fh = p_mh;
						center_crop(sw, sh, fw, fh, cx, cy, cw, ch);
					end
				end
			end
			FIT_HEIGHT: begin
				if (p_enlarge || sh > th) begin
					if (sh != th) begin
						fh = th; fw = round_div(th * sw, sh); sc = 1;
					end
					if (p_rmax && fw > p_mw) begin
						fw = p_mw;
						center_crop(sw, sh, fw, fh, cx, cy, cw, ch);
					end
				end
			end
			FIT_FILL: begin
				if (p_enlarge || sw > tw || sh > th) begin
					fw = tw; fh = th; sc = (sw != tw || sh != th);
					center_crop(sw, sh, tw, th, cx, cy, cw, ch);
				end
			end
			default: ;
		endcase
		r.fw = DW'(clip_dim(fw)); r.fh = DW'(clip_dim(fh));
		r.cx = DW'(clip_dim(cx)); r.cy = DW'(clip_dim(cy));
		r.cw = DW'(clip_dim(cw)); r.ch = DW'(clip_dim(ch));
		r.sc = sc;
		return r;
	endfunction

	// input handshake seen at the rising edge, used by the driver
	always @(posedge clk) begin
		in_fire <= src_ch.valid && src_ch.ready;
	end

	// driver: bursts with random gaps, fed from pending_sizes
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			// retire the transaction that was accepted at the last rising edge
			if (in_fire)
				void'(pending_sizes.pop_front());
			if (src_ch.valid && !in_fire) begin
				// a waiting transaction stays on the bus
				src_ch.valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				src_ch.valid <= 1'b0;
			end else if (pending_sizes.size() > 0 && !hold_sender) begin
				src_ch.valid <= 1'b1;
				src_ch.src_width <= pending_sizes[0].w;
				src_ch.src_height <= pending_sizes[0].h;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				src_ch.valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern: alternate free runs and choppy stretches
	int stall_phase = 0;
	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if ((stall_phase / 300) % 3 == 0)
			res_ch.ready <= 1'b1;
		else if ((stall_phase / 300) % 3 == 1)
			res_ch.ready <= ($urandom_range(0, 3) != 0);
		else
			res_ch.ready <= ((stall_phase % 7) < 4) && ($urandom_range(0, 1) == 1);
	end

	// monitor: predict on input acceptance, compare on output acceptance
	always @(posedge clk) begin
		fit_result_t got, exp_r;
		if (arst_n) begin
			if (src_ch.valid && src_ch.ready)
				expected_fits.push_back(predict_fit({src_ch.src_width, src_ch.src_height}));
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.fitted_width, res_ch.fitted_height, res_ch.crop_x,
					res_ch.crop_y, res_ch.crop_width, res_ch.crop_height, res_ch.scaled};
				results_seen++;
				if (expected_fits.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					exp_r = expected_fits.pop_front();
					if (got.fw !== exp_r.fw) begin
						$error("fitted_width exp %0d got %0d", exp_r.fw, got.fw); fail_count++;
					end
					if (got.fh !== exp_r.fh) begin
						$error("fitted_height exp %0d got %0d", exp_r.fh, got.fh); fail_count++;
					end
					if (got.cx !== exp_r.cx) begin
						$error("crop_x exp %0d got %0d", exp_r.cx, got.cx); fail_count++;
					end
					if (got.cy !== exp_r.cy) begin
						$error("crop_y exp %0d got %0d", exp_r.cy, got.cy); fail_count++;
					end
					if (got.cw !== exp_r.cw) begin
						$error("crop_width exp %0d got %0d", exp_r.cw, got.cw); fail_count++;
					end
					if (got.ch !== exp_r.ch) begin
						$error("crop_height exp %0d got %0d", exp_r.ch, got.ch); fail_count++;
					end
					if (got.sc !== exp_r.sc) begin
						$error("scaled exp %0d got %0d", exp_r.sc, got.sc); fail_count++;
					end
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((src_ch.valid && src_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results still expected", expected_fits.size());
			$display("tb_image_size_fit_and_crop NOT OK");
			$finish;
		end
	end

	// register write at a falling edge, mirrored into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TARGET_W: p_tw = val;
			CFG_TARGET_H: p_th = val;
			CFG_MAX_W:    p_mw = val;
			CFG_MAX_H:    p_mh = val;
			CFG_MODE:     p_mode = val[2:0];
			CFG_ORIENT:   p_orient = val[0];
			CFG_ENLARGE:  p_enlarge = val[0];
			CFG_RMAX:     p_rmax = val[0];
			default: ;
		endcase
	endtask

	// wait until the block has drained everything
	task automatic drain_block();
		while (pending_sizes.size() > 0 || expected_fits.size() > 0 || src_ch.valid)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [DW-1:0] rand_dim();
		// mostly modest sizes, sometimes extremes or full range
		case ($urandom_range(0, 7))
			0: return DW'($urandom_range(1, 4));
			1: return DW'($urandom_range(65530, 65535));
			2: return DW'($urandom_range(1, 65535));
			default: return DW'($urandom_range(1, 3000));
		endcase
	endfunction

	task automatic queue_size(input logic [DW-1:0] w, h);
		pending_sizes.push_back({w, h});
	endtask

	task automatic random_config();
		write_reg(CFG_TARGET_W, ($urandom_range(0, 9) == 0) ? 16'd65535 : rand_dim());
		write_reg(CFG_TARGET_H, ($urandom_range(0, 9) == 0) ? 16'd1 : rand_dim());
		write_reg(CFG_MAX_W, rand_dim());
		write_reg(CFG_MAX_H, rand_dim());
		write_reg(CFG_MODE, DW'($urandom_range(0, 7)));
		write_reg(CFG_ORIENT, DW'($urandom_range(0, 1)));
		write_reg(CFG_ENLARGE, DW'($urandom_range(0, 1)));
		write_reg(CFG_RMAX, DW'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
		src_ch.valid = 1'b0; src_ch.src_width = '0; src_ch.src_height = '0;
		res_ch.ready = 1'b0;
		p_tw = DW'(TARGET_W_RST); p_th = DW'(TARGET_H_RST);
		p_mw = DW'(MAX_W_RST); p_mh = DW'(MAX_H_RST);
		p_mode = FIT_FILL; p_orient = 1'b1; p_enlarge = 1'b0; p_rmax = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, portrait swap, small pass-through, extremes
		queue_size(16'd1920, 16'd1080);
		queue_size(16'd1080, 16'd1920);
		queue_size(16'd320, 16'd240);
		queue_size(16'd640, 16'd480);
		queue_size(16'd65535, 16'd1);
		queue_size(16'd1, 16'd65535);
		queue_size(16'd65535, 16'd65535);
		drain_block();

		// fit inside with enlarge, both long-side branches and the second rescale
		write_reg(CFG_MODE, DW'(FIT_INSIDE));
		write_reg(CFG_ENLARGE, 16'd1);
		queue_size(16'd100, 16'd50);
		queue_size(16'd50, 16'd100);
		queue_size(16'd1000, 16'd999);
		queue_size(16'd1, 16'd1);
		drain_block();

		// fit width and height, equal size and max clamp crop
		write_reg(CFG_MODE, DW'(FIT_WIDTH));
		write_reg(CFG_RMAX, 16'd1);
		write_reg(CFG_MAX_H, 16'd100);
		write_reg(CFG_MAX_W, 16'd100);
		queue_size(16'd640, 16'd480);
		queue_size(16'd320, 16'd1000);
		queue_size(16'd65535, 16'd65535);
		drain_block();
		write_reg(CFG_MODE, DW'(FIT_HEIGHT));
		queue_size(16'd640, 16'd480);
		queue_size(16'd2000, 16'd100);
		queue_size(16'd1, 16'd65535);
		drain_block();

		// mode none and an undefined mode pass through
		write_reg(CFG_MODE, DW'(FIT_NONE));
		queue_size(16'd1234, 16'd77);
		drain_block();
		write_reg(CFG_MODE, 16'd7);
		queue_size(16'd77, 16'd1234);
		drain_block();

		// extreme targets
		write_reg(CFG_TARGET_W, 16'd65535);
		write_reg(CFG_TARGET_H, 16'd1);
		write_reg(CFG_MODE, DW'(FIT_FILL));
		write_reg(CFG_ORIENT, 16'd0);
		queue_size(16'd1, 16'd65535);
		queue_size(16'd43690, 16'd21845);
		drain_block();

		// random phases, each under a new register setting
		for (int ph = 0; ph < 13; ph++) begin
			random_config();
			for (int k = 0; k < 50; k++)
				queue_size(rand_dim(), rand_dim());
			if (ph == 6) begin
				// hold the sender until every expected result has come
				while (pending_sizes.size() > 40) @(posedge clk);
				hold_sender = 1;
				while (expected_fits.size() > 0 || src_ch.valid) @(posedge clk);
				hold_sender = 0;
			end
			drain_block();
		end

		$display("ran %0d results over all fit modes, option mixes and extreme sizes",
			results_seen);
		if (fail_count == 0 && expected_fits.size() == 0)
			$display("tb_image_size_fit_and_crop OK");
		else
			$display("tb_image_size_fit_and_crop NOT OK");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/isfc_pkg.sv
src/isfc_src_if.sv
src/isfc_res_if.sv
src/isfc_rdiv_pipe.sv
src/image_size_fit_and_crop.sv
sim/tb_image_size_fit_and_crop.sv
